[rtl/fsp_pkg.sv]
// Shared constants and types of the framed sum-checked packet parser.
`timescale 1ns / 1ps
`default_nettype none

package fsp_pkg;

    localparam int MAX_LEN = 20;
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int KEEP_BYTES = 7;
    localparam int KEEP_IDX_W = $clog2(KEEP_BYTES);

    localparam logic [7:0] HEAD_BYTE = 8'hEF;
    localparam logic [7:0] TAIL_BYTE = 8'hFE;
    localparam logic [7:0] TYPE_TARGET = 8'h0C;
    localparam logic [7:0] COUNT_NONE = 8'hFF;
    localparam logic [7:0] MAX_LEN_BYTE = 8'(MAX_LEN);

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_LEN  = 5'b00010,
        PH_DATA = 5'b00100,
        PH_SUM  = 5'b01000,
        PH_TAIL = 5'b10000
    } phase_t;

    typedef struct packed {
        logic signed [15:0] target_location;
        logic signed [15:0] target_width;
        logic [7:0]         target_count;
    } target_t;

    typedef struct packed {
        logic    emit;
        target_t target;
    } parse_result_t;

endpackage

`default_nettype wire

[rtl/fsp_byte_if.sv]
// Valid/ready channel that carries one received byte per request.
`timescale 1ns / 1ps
`default_nettype none

interface fsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[rtl/fsp_result_if.sv]
// Valid/ready channel that carries one decoded target report per request.
`timescale 1ns / 1ps
`default_nettype none

interface fsp_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] target_location;
    logic signed [15:0] target_width;
    logic [7:0]         target_count;

    modport source (output valid, output target_location, output target_width,
                    output target_count, input ready);
    modport sink (input valid, input target_location, input target_width,
                  input target_count, output ready);
endinterface

`default_nettype wire

[rtl/framed_sum_checked_packet_parser_top.sv]
// Top level of the framed sum-checked packet parser.
//
// The rx channel takes one received byte per request. Bytes form frames of a
// 0xEF header, a length byte, the payload, an 8-bit modulo sum of the payload
// and a 0xFE trailer. When a good frame whose first payload byte is 0x0C ends,
// one request leaves on the target channel with the location, the width and
// the count decoded from payload bytes 1 to 4 and 6. Other frames end silently.
// Throughput is one byte per cycle while no report waits on a stalled
// receiver: the byte sits in an input register, the frame state machine and
// checksum adder act on it as it leaves, and the report lands in a result
// register. A report thus passes the input and the result register after the
// trailer byte is accepted. The rate is set by that single state update per byte.
// While the receiver stalls with a report pending, the parser stops consuming;
// at most one more byte is taken into the input register, then rx.ready drops
// until the report is taken. Nothing is lost or repeated.
// Reset returns the parser to waiting for a header, clears the checksum, the
// counters and the seven stored payload bytes, and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module framed_sum_checked_packet_parser_top (
    input  wire logic    clk,
    input  wire logic    rst_n,
    fsp_byte_if.sink     rx,
    fsp_result_if.source target
);
    import fsp_pkg::*;

    logic          step;
    logic          out_free;
    logic [7:0]    byte_q;
    parse_result_t result;

    // Holds the incoming byte; it moves on whenever the result side has room.
    fsp_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .out_free (out_free),
        .step     (step),
        .byte_q   (byte_q)
    );

    // Frame recognition, checksum and payload capture.
    fsp_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .byte_q (byte_q),
        .result (result)
    );

    // Keeps a finished report until the receiver accepts it.
    fsp_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .result   (result),
        .out_free (out_free),
        .target   (target)
    );

endmodule

`default_nettype wire

[rtl/fsp_in_stage.sv]
// Input register that holds one received byte until the parser consumes it.
`timescale 1ns / 1ps
`default_nettype none

module fsp_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    fsp_byte_if.sink        rx,
    input  wire logic       out_free,
    output logic            step,
    output logic [7:0]      byte_q
);
    import fsp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    // The held byte is consumed whenever the result register can take an answer.
    assign step     = valid_reg && out_free;
    assign rx.ready = !valid_reg || step;
    assign take     = rx.valid && rx.ready;
    assign byte_q   = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (step)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= rx.rx_byte;
        end
    end

endmodule

`default_nettype wire

[rtl/fsp_parser.sv]
// Frame state machine, running checksum and stored payload head.
`timescale 1ns / 1ps
`default_nettype none

module fsp_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [7:0]      byte_q,
    output fsp_pkg::parse_result_t result
);
    import fsp_pkg::*;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [7:0]       length_reg;
    logic [7:0]       length_next;
    logic [CNT_W-1:0] taken_reg;
    logic [CNT_W-1:0] taken_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    logic [7:0]       head_reg [KEEP_BYTES];
    logic             store;
    logic [CNT_W-1:0] taken_inc;

    assign taken_inc = taken_reg + CNT_W'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        taken_next  = taken_reg;
        sum_next    = sum_reg;
        store       = 1'b0;
        result.emit = 1'b0;
        result.target.target_location = {head_reg[1], head_reg[2]};
        result.target.target_width    = {head_reg[3], head_reg[4]};
        result.target.target_count    = (head_reg[6] == COUNT_NONE) ? 8'h00 : head_reg[6];
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (byte_q == HEAD_BYTE)
                begin
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                sum_next    = 8'h00;
                taken_next  = '0;
                length_next = byte_q;
                phase_next  = (byte_q > MAX_LEN_BYTE) ? PH_IDLE : PH_DATA;
            end
            PH_DATA:
            begin
                store      = (taken_reg < CNT_W'(KEEP_BYTES));
                sum_next   = sum_reg + byte_q;
                taken_next = taken_inc;
                // A zero length still ends after the first payload byte.
                if (8'(taken_inc) >= length_reg)
                begin
                    phase_next = PH_SUM;
                end
            end
            PH_SUM:
            begin
                phase_next = (byte_q == sum_reg) ? PH_TAIL : PH_IDLE;
            end
            PH_TAIL:
            begin
                result.emit = (byte_q == TAIL_BYTE) && (head_reg[0] == TYPE_TARGET);
                phase_next  = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            length_reg <= 8'h00;
            taken_reg  <= '0;
            sum_reg    <= 8'h00;
            for (int i = 0; i < KEEP_BYTES; i++)
            begin
                head_reg[i] <= 8'h00;
            end
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            taken_reg  <= taken_next;
            sum_reg    <= sum_next;
            if (store)
            begin
                head_reg[taken_reg[KEEP_IDX_W-1:0]] <= byte_q;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/fsp_out_stage.sv]
// Result register that holds a target report until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none

module fsp_out_stage (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire fsp_pkg::parse_result_t result,
    output logic                       out_free,
    fsp_result_if.source               target
);
    import fsp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    target_t data_reg;
    logic    load;

    assign out_free = !valid_reg || target.ready;
    assign load     = step && result.emit;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_free)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result.target;
        end
    end

    assign target.valid           = valid_reg;
    assign target.target_location = data_reg.target_location;
    assign target.target_width    = data_reg.target_width;
    assign target.target_count    = data_reg.target_count;

endmodule

`default_nettype wire

[tb/target_report_checker.sv]
// Checker that predicts target reports from the byte stream and compares them.
`timescale 1ns / 1ps

module target_report_checker
    import fsp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    fsp_byte_if       rx,
    fsp_result_if     target,
    output int        fail_count,
    output int        pending
);

    // Shadow copy of the parser state.
    phase_t     phase;
    logic [7:0] frame_len;
    int         taken;
    logic [7:0] frame_sum;
    logic [7:0] head [KEEP_BYTES];

    target_t    expected_reports [$];
    target_t    got;
    target_t    want;

    task automatic note_failure(input string what);
        if (fail_count < 10)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        fail_count++;
    endtask

    // Advances the shadow parser by one byte and queues a report when a good
    // target frame closes.
    task automatic parse_rx_byte(input logic [7:0] b);
        target_t rpt;
        case (phase)
            PH_IDLE:
            begin
                if (b == HEAD_BYTE)
                begin
                    phase = PH_LEN;
                end
            end
            PH_LEN:
            begin
                frame_sum = '0;
                taken     = 0;
                frame_len = b;
                phase     = (b > MAX_LEN_BYTE) ? PH_IDLE : PH_DATA;
            end
            PH_DATA:
            begin
                if (taken < KEEP_BYTES)
                begin
                    head[taken] = b;
                end
                frame_sum = frame_sum + b;
                taken++;
                // A zero length still lands here once, so one byte is taken.
                if (taken >= frame_len)
                begin
                    phase = PH_SUM;
                end
            end
            PH_SUM:
            begin
                phase = (b == frame_sum) ? PH_TAIL : PH_IDLE;
            end
            PH_TAIL:
            begin
                if (b == TAIL_BYTE && head[0] == TYPE_TARGET)
                begin
                    rpt.target_location = {head[1], head[2]};
                    rpt.target_width    = {head[3], head[4]};
                    rpt.target_count    = (head[6] == COUNT_NONE) ? 8'd0 : head[6];
                    expected_reports.push_back(rpt);
                end
                phase = PH_IDLE;
            end
            default:
            begin
                phase = PH_IDLE;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase     = PH_IDLE;
            frame_len = '0;
            taken     = 0;
            frame_sum = '0;
            foreach (head[i])
            begin
                head[i] = '0;
            end
            expected_reports.delete();
            pending <= 0;
        end
        else
        begin
            if (target.valid && target.ready)
            begin
                got.target_location = target.target_location;
                got.target_width    = target.target_width;
                got.target_count    = target.target_count;
                if (expected_reports.size() == 0)
                begin
                    note_failure($sformatf("report with none expected: loc %0d width %0d count %0d",
                        $signed(got.target_location), $signed(got.target_width),
                        got.target_count));
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.target_location !== want.target_location)
                    begin
                        note_failure($sformatf("target_location expected %0d, got %0d",
                            $signed(want.target_location), $signed(got.target_location)));
                    end
                    if (got.target_width !== want.target_width)
                    begin
                        note_failure($sformatf("target_width expected %0d, got %0d",
                            $signed(want.target_width), $signed(got.target_width)));
                    end
                    if (got.target_count !== want.target_count)
                    begin
                        note_failure($sformatf("target_count expected %0d, got %0d",
                            want.target_count, got.target_count));
                    end
                end
            end
            if (rx.valid && rx.ready)
            begin
                parse_rx_byte(rx.rx_byte);
            end
            pending <= expected_reports.size();
        end
    end

endmodule

[tb/tb_top.sv]
// Top of the parser testbench: clock, reset, byte stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_top;
    import fsp_pkg::*;

    localparam int CLK_HALF          = 5;
    localparam int RESET_CYCLES      = 9;
    // Frame bytes to send in the random part, spread over four idling phases.
    // The directed part adds about a hundred more.
    localparam int RANDOM_BYTES      = 520;
    // A request is accepted on one side or the other well within this many
    // cycles even at the heaviest idling; a longer silence means a hang.
    localparam int QUIET_LIMIT       = 2000;
    // A report passes the input and result registers after its trailer; this leaves ample margin.
    localparam int DRAIN_CYCLES      = 8;

    localparam int SEND_IDLE_PCT [4]  = '{0, 78, 0, 11};
    localparam int RECV_STALL_PCT [4] = '{0, 0, 78, 11};

    logic clk = 1'b0;
    logic rst_n;

    fsp_byte_if   rx ();
    fsp_result_if target ();

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int frame_bytes   = 0;
    int quiet_cycles  = 0;
    int fail_count;
    int pending;

    // Payload of the frame about to be sent.
    logic [7:0] body [$];

    framed_sum_checked_packet_parser_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx),
        .target (target)
    );

    target_report_checker report_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx),
        .target      (target),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always #CLK_HALF clk = ~clk;

    // The receiver drops ready at random, at the rate of the current phase.
    // There is exactly one assignment per clock edge, so no glitch is possible.
    always @(posedge clk)
    begin
        target.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: the run is declared hung if no request moves on either
    // channel before the count of quiet cycles reaches QUIET_LIMIT.
    always @(posedge clk)
    begin
        if (!rst_n || (rx.valid && rx.ready) || (target.valid && target.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Byte source biased toward the values that matter to the parser: the
    // header and trailer codes, the count sentinel and the sign boundaries.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0:       return HEAD_BYTE;
            1:       return TAIL_BYTE;
            2:       return 8'h00;
            3:       return COUNT_NONE;
            4:       return 8'h80;
            5:       return 8'h7F;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] body_sum();
        logic [7:0] acc;
        acc = '0;
        foreach (body[i])
        begin
            acc = acc + body[i];
        end
        return acc;
    endfunction

    // Sends one byte request. Before it, the sender may idle for a random
    // number of cycles; valid then stays high until the byte is accepted.
    // The task returns on the edge that accepted the byte, so the caller's
    // next assignment to valid lands on that same edge exactly once.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            rx.valid <= 1'b0;
            @(posedge clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        @(posedge clk);
        while (!rx.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Sends header, length byte and the first keep bytes of body. A frame cut
    // short (keep below the body size) ends there; otherwise the checksum,
    // flipped by sum_xor, and the given trailer follow.
    task automatic send_frame(input logic [7:0] len_byte, input logic [7:0] sum_xor,
                              input logic [7:0] tail, input int keep);
        logic [7:0] csum;
        csum = body_sum();
        send_byte(HEAD_BYTE);
        send_byte(len_byte);
        for (int i = 0; i < keep; i++)
        begin
            send_byte(body[i]);
        end
        frame_bytes += keep + 2;
        if (keep < body.size())
        begin
            return;
        end
        send_byte(csum ^ sum_xor);
        send_byte(tail);
        frame_bytes += 2;
    endtask

    // One random frame. Most are well formed with random content, mostly of
    // the target type; the rest have a bad checksum, a bad trailer, are cut
    // short, or carry a length beyond the limit. Line noise may come first.
    task automatic send_random_frame();
        int         len;
        int         n_body;
        int         pick;
        logic [7:0] tail;
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(3, 1)) send_byte(pick_byte());
        end
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            len = $urandom_range(MAX_LEN, KEEP_BYTES);
        end
        else if (pick < 93)
        begin
            len = $urandom_range(KEEP_BYTES - 1, 0);
        end
        else
        begin
            len = $urandom_range(255, MAX_LEN + 1);
        end
        // A zero length still takes one byte; an oversized one gets a short
        // tail of bytes that the parser sees while idle.
        n_body = (len == 0) ? 1 : (len > MAX_LEN) ? $urandom_range(8, 1) : len;
        body.delete();
        pick = $urandom_range(99);
        if (pick < 65)
        begin
            body.push_back(TYPE_TARGET);
        end
        else if (pick < 80)
        begin
            body.push_back(8'h0A + 8'($urandom_range(1)));
        end
        else
        begin
            body.push_back(pick_byte());
        end
        while (body.size() < n_body)
        begin
            body.push_back(pick_byte());
        end
        pick = $urandom_range(99);
        if (pick < 80)
        begin
            send_frame(8'(len), 8'h00, TAIL_BYTE, n_body);
        end
        else if (pick < 88)
        begin
            send_frame(8'(len), 8'($urandom_range(255, 1)), TAIL_BYTE, n_body);
        end
        else if (pick < 94)
        begin
            tail = pick_byte();
            while (tail == TAIL_BYTE)
            begin
                tail = pick_byte();
            end
            send_frame(8'(len), 8'h00, tail, n_body);
        end
        else
        begin
            send_frame(8'(len), 8'h00, TAIL_BYTE, $urandom_range(n_body - 1));
        end
    endtask

    // Four bytes that form a complete one-byte target frame if, and only if,
    // the byte just before them was wrongly taken as a header.
    task automatic send_header_probe();
        send_byte(8'h01);
        send_byte(TYPE_TARGET);
        send_byte(TYPE_TARGET);
        send_byte(TAIL_BYTE);
    endtask

    initial
    begin
        int start_bytes;

        rst_n        = 1'b0;
        rx.valid     = 1'b0;
        rx.rx_byte   = 8'h00;
        target.ready = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // ---- Directed part, sent with no idling on either side ----

        // Bytes other than the header are ignored while idle.
        send_byte(8'h00);
        send_byte(8'hFF);

        // Short frame right after reset: the bytes it leaves out read as zero.
        body = '{TYPE_TARGET, 8'h12, 8'h34};
        send_frame(8'd3, 8'h00, TAIL_BYTE, 3);

        // Seven bytes: most negative location, most positive width, and the
        // count sentinel, which must be reported as zero.
        body = '{TYPE_TARGET, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'h5A, COUNT_NONE};
        send_frame(8'd7, 8'h00, TAIL_BYTE, 7);

        // Longest legal frame; bytes past the stored seven only enter the
        // checksum. The count is the largest reportable value.
        body = '{TYPE_TARGET, 8'h7F, 8'hFF, 8'h80, 8'h00, 8'hA5, 8'hFE};
        repeat (MAX_LEN - KEEP_BYTES) body.push_back(pick_byte());
        send_frame(8'(MAX_LEN), 8'h00, TAIL_BYTE, MAX_LEN);

        // Zero length takes one byte; the report carries the stale bytes.
        body = '{TYPE_TARGET};
        send_frame(8'd0, 8'h00, TAIL_BYTE, 1);

        // A good frame of another type closes without a report.
        body = '{8'h0A, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06};
        send_frame(8'd7, 8'h00, TAIL_BYTE, 7);

        // Bad checksum that happens to equal the header code: the parser goes
        // idle and must not restart on it.
        body = '{TYPE_TARGET, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66};
        send_frame(8'd7, body_sum() ^ HEAD_BYTE, 8'h01, 7);
        send_byte(TYPE_TARGET);
        send_byte(TYPE_TARGET);
        send_byte(TAIL_BYTE);

        // Bad trailer equal to the header code: same rule.
        send_frame(8'd7, 8'h00, HEAD_BYTE, 7);
        send_header_probe();

        // Length one above the limit drops the frame; a fresh header right
        // after it is honored.
        send_byte(HEAD_BYTE);
        send_byte(8'(MAX_LEN + 1));
        send_byte(HEAD_BYTE);
        send_header_probe();

        // An oversized length equal to the header code is not a new header.
        send_byte(HEAD_BYTE);
        send_byte(HEAD_BYTE);
        send_header_probe();

        // ---- Random part, one pass per idling phase ----
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = SEND_IDLE_PCT[ph];
            stall_pct     = RECV_STALL_PCT[ph];
            start_bytes   = frame_bytes;
            while (frame_bytes - start_bytes < RANDOM_BYTES / 4)
            begin
                send_random_frame();
            end
        end

        // Everything is sent: let the last reports drain, then give a margin
        // in which any stray report would still be caught.
        rx.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
